@@ hdl/udp_port_packet_classifier_core_defines.svh @@
// assertion macros shared by the udp port classifier rtl
// expects signals clk and rst in the module that expands them
`ifndef UDP_PORT_PACKET_CLASSIFIER_CORE_DEFINES_SVH
`define UDP_PORT_PACKET_CLASSIFIER_CORE_DEFINES_SVH

// condition holds at every clock edge out of reset
`define UPC_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the clock after the antecedent
`define UPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/upc_pkg.sv @@
// package of the udp port classifier: constants, register codes, record types
// no dependencies
package upc_pkg;

  localparam int NUM_QUEUES_DEF   = 4;
  localparam int NUM_PORTS_DEF    = 4;
  localparam int COUNTER_BITS_DEF = 32;

  localparam int QUEUE_W   = 2;
  localparam int OUT_CNT_W = 32;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int POS_W     = 6;
  localparam int LEN_W     = 7;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [7:0]  PROTO_REDIRECT = 8'd248;

  localparam logic [LEN_W-1:0] LEN_IP  = 7'd34;
  localparam logic [LEN_W-1:0] LEN_UDP = 7'd42;

  localparam logic [POS_W-1:0] POS_ETYPE_HI = 6'd12;
  localparam logic [POS_W-1:0] POS_ETYPE_LO = 6'd13;
  localparam logic [POS_W-1:0] POS_PROTO    = 6'd23;
  localparam logic [POS_W-1:0] POS_DPORT_HI = 6'd36;
  localparam logic [POS_W-1:0] POS_DPORT_LO = 6'd37;
  localparam logic [POS_W-1:0] POS_MAX      = 6'd63;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  typedef enum logic [2:0] {
    REG_QUEUE_ENABLE = 3'd0,
    REG_PORT_A       = 3'd1,
    REG_PORT_B       = 3'd2,
    REG_PORT_C       = 3'd3,
    REG_PORT_D       = 3'd4,
    REG_PORT_VALID   = 3'd5
  } upc_reg_t;

  typedef struct packed {
    logic [3:0] queue_enable_mask;
    logic [3:0] allow_port_valid;
  } upc_cfg_t;

  typedef struct packed {
    logic               redirect;
    logic               udp_inc;
    logic               hit_inc;
    logic               qvalid;
    logic [QUEUE_W-1:0] queue;
  } upc_rec_t;

endpackage

@@ hdl/udp_port_packet_classifier_core.sv @@
// top level of the udp destination port classifier
// depends on upc_pkg, upc_regs, upc_front, upc_fifo, upc_back
//
// usage:
//   input channel: one frame byte per item (data_byte, frame_queue, last_byte),
//   taken at a clock edge with push high and full low; frame_queue is sampled
//   with the byte marked last_byte
//   result channel: one verdict item per frame, present while empty is low,
//   taken at a clock edge with pop high; counters in the item are their values
//   after this frame
//   config: apb write with setup and access cycle, pready tied high; registers
//   at byte addresses 0,4,..,20 in the order mask, port a..d, port valid
// verdict path: the verdict of a frame enters the verdict queue at the edge
//   that takes its last byte, and passes into the result register when free
// throughput: one byte per clock while full is low; the front end decides in
//   the last byte's cycle; counters retire one verdict per clock unless stalled
// stall: a four-entry verdict queue plus the result register absorb a stalled
//   receiver; full rises only when all are occupied, and it holds off all bytes
// reset: clears position, captured header fields, counters, registers, queue
module udp_port_packet_classifier_core #(
  parameter int NUM_QUEUES   = upc_pkg::NUM_QUEUES_DEF,
  parameter int NUM_PORTS    = upc_pkg::NUM_PORTS_DEF,
  parameter int COUNTER_BITS = upc_pkg::COUNTER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // byte input, queue style
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    data_byte,
  input  logic [upc_pkg::QUEUE_W-1:0]   frame_queue,
  input  logic                          last_byte,
  // verdict output, queue style
  output logic                          empty,
  input  logic                          pop,
  output logic                          redirect,
  output logic [upc_pkg::QUEUE_W-1:0]   target_queue,
  output logic [upc_pkg::OUT_CNT_W-1:0] udp_seen_total,
  output logic [upc_pkg::OUT_CNT_W-1:0] port_hit_total,
  output logic [upc_pkg::OUT_CNT_W-1:0] queue_redirect_total,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [upc_pkg::PADDR_W-1:0]   paddr,
  input  logic [upc_pkg::PDATA_W-1:0]   pwdata,
  output logic [upc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  // only four port registers exist in the map
  localparam int PDEPTH = (NUM_PORTS < 4) ? NUM_PORTS : 4;

  upc_pkg::upc_cfg_t      cfg;
  logic [PDEPTH-1:0][15:0] allow_ports;
  logic                   accept;
  logic                   rec_valid;
  upc_pkg::upc_rec_t      rec;
  logic                   fifo_full;
  logic                   fifo_empty;
  logic                   fifo_rd;
  upc_pkg::upc_rec_t      fifo_rec;
  logic                   out_valid;

  assign pready = 1'b1;
  assign full   = fifo_full;
  assign accept = push && !fifo_full;
  assign empty  = !out_valid;

  upc_regs #(
    .PDEPTH (PDEPTH)
  ) u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .cfg         (cfg),
    .allow_ports (allow_ports)
  );

  // front end: parses bytes and writes one verdict record per frame
  upc_front #(
    .NUM_QUEUES (NUM_QUEUES),
    .PDEPTH     (PDEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (data_byte),
    .frame_queue (frame_queue),
    .last_byte   (last_byte),
    .cfg         (cfg),
    .allow_ports (allow_ports),
    .rec_valid   (rec_valid),
    .rec         (rec)
  );

  upc_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (rec_valid),
    .wdata (rec),
    .full  (fifo_full),
    .rd    (fifo_rd),
    .rdata (fifo_rec),
    .empty (fifo_empty)
  );

  // back end: counters and result register, drained by pop
  upc_back #(
    .NUM_QUEUES   (NUM_QUEUES),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk                  (clk),
    .rst                  (rst),
    .fifo_empty           (fifo_empty),
    .fifo_rec             (fifo_rec),
    .fifo_rd              (fifo_rd),
    .pop                  (pop),
    .out_valid            (out_valid),
    .redirect             (redirect),
    .target_queue         (target_queue),
    .udp_seen_total       (udp_seen_total),
    .port_hit_total       (port_hit_total),
    .queue_redirect_total (queue_redirect_total)
  );

endmodule

@@ hdl/upc_regs.sv @@
// apb configuration registers of the udp port classifier
// depends on upc_pkg
module upc_regs #(
  parameter int PDEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [upc_pkg::PADDR_W-1:0] paddr,
  input  logic [upc_pkg::PDATA_W-1:0] pwdata,
  output logic [upc_pkg::PDATA_W-1:0] prdata,
  output upc_pkg::upc_cfg_t          cfg,
  output logic [PDEPTH-1:0][15:0]    allow_ports
);

  logic       wr;
  logic [2:0] idx;
  logic [3:0] queue_enable_mask;
  logic [3:0] allow_port_valid;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_enable_mask <= '0;
      allow_port_valid  <= '0;
    end else if (wr) begin
      case (idx)
        upc_pkg::REG_QUEUE_ENABLE: queue_enable_mask <= pwdata[3:0];
        upc_pkg::REG_PORT_VALID:   allow_port_valid  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // port registers past the configured count do not exist
  for (genvar i = 0; i < PDEPTH; i++) begin : g_port
    always_ff @(posedge clk) begin
      if (rst) begin
        allow_ports[i] <= '0;
      end else if (wr && idx == 3'(int'(upc_pkg::REG_PORT_A) + i)) begin
        allow_ports[i] <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      upc_pkg::REG_QUEUE_ENABLE: prdata = 32'(queue_enable_mask);
      upc_pkg::REG_PORT_VALID:   prdata = 32'(allow_port_valid);
      default: ;
    endcase
    for (int i = 0; i < PDEPTH; i++) begin
      if (idx == 3'(int'(upc_pkg::REG_PORT_A) + i)) begin
        prdata = 32'(allow_ports[i]);
      end
    end
  end

  assign cfg.queue_enable_mask = queue_enable_mask;
  assign cfg.allow_port_valid  = allow_port_valid;

endmodule

@@ hdl/upc_front.sv @@
// front end: byte position tracking, header capture and verdict decision
// depends on upc_pkg and the assertion macro header
`include "udp_port_packet_classifier_core_defines.svh"

module upc_front #(
  parameter int NUM_QUEUES = upc_pkg::NUM_QUEUES_DEF,
  parameter int PDEPTH     = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [7:0]                  data_byte,
  input  logic [upc_pkg::QUEUE_W-1:0] frame_queue,
  input  logic                        last_byte,
  input  upc_pkg::upc_cfg_t           cfg,
  input  logic [PDEPTH-1:0][15:0]     allow_ports,
  output logic                        rec_valid,
  output upc_pkg::upc_rec_t           rec
);

  logic [upc_pkg::POS_W-1:0] pos;
  logic [15:0]               ethertype_word;
  logic [7:0]                protocol_byte;
  logic [15:0]               dest_port_word;

  logic [15:0]               ety_now;
  logic [7:0]                proto_now;
  logic [15:0]               dport_now;
  logic [upc_pkg::LEN_W-1:0] len;
  logic                      qvalid;
  logic                      enabled;
  logic                      ipv4_ok;
  logic                      udp_ok;
  logic                      match;

  // header fields including the byte being taken now
  always_comb begin
    ety_now   = ethertype_word;
    proto_now = protocol_byte;
    dport_now = dest_port_word;
    if (pos == upc_pkg::POS_ETYPE_HI) ety_now[15:8]  = data_byte;
    if (pos == upc_pkg::POS_ETYPE_LO) ety_now[7:0]   = data_byte;
    if (pos == upc_pkg::POS_PROTO)    proto_now      = data_byte;
    if (pos == upc_pkg::POS_DPORT_HI) dport_now[15:8] = data_byte;
    if (pos == upc_pkg::POS_DPORT_LO) dport_now[7:0]  = data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos            <= '0;
      ethertype_word <= '0;
      protocol_byte  <= '0;
      dest_port_word <= '0;
    end else if (accept) begin
      if (last_byte) begin
        pos            <= '0;
        ethertype_word <= '0;
        protocol_byte  <= '0;
        dest_port_word <= '0;
      end else begin
        if (pos != upc_pkg::POS_MAX) pos <= pos + 1'b1;
        ethertype_word <= ety_now;
        protocol_byte  <= proto_now;
        dest_port_word <= dport_now;
      end
    end
  end

  always_comb begin
    match = 1'b0;
    for (int i = 0; i < PDEPTH; i++) begin
      if (cfg.allow_port_valid[i] && allow_ports[i] == dport_now) match = 1'b1;
    end
  end

  assign len     = upc_pkg::LEN_W'(pos) + 1'b1;
  assign qvalid  = 7'(frame_queue) < 7'(NUM_QUEUES);
  assign enabled = qvalid && cfg.queue_enable_mask[frame_queue];
  assign ipv4_ok = enabled && len >= upc_pkg::LEN_IP && ety_now == upc_pkg::ETHERTYPE_IPV4;
  assign udp_ok  = ipv4_ok && proto_now == upc_pkg::PROTO_UDP && len >= upc_pkg::LEN_UDP;

  assign rec_valid    = accept && last_byte;
  assign rec.redirect = (ipv4_ok && proto_now == upc_pkg::PROTO_REDIRECT) || (udp_ok && match);
  assign rec.udp_inc  = udp_ok;
  assign rec.hit_inc  = udp_ok && match;
  assign rec.qvalid   = qvalid;
  assign rec.queue    = frame_queue;

  `UPC_ASSERT_NEXT(a_pos_clear, accept && last_byte, pos == '0, "position not cleared")
  `UPC_ASSERT_NOW(a_redir_enabled, !(rec_valid && rec.redirect) || enabled, "redirect on disabled queue")

endmodule

@@ hdl/upc_fifo.sv @@
// short record queue between the front end and the counter stage
// depends on upc_pkg and the assertion macro header
`include "udp_port_packet_classifier_core_defines.svh"

module upc_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  upc_pkg::upc_rec_t wdata,
  output logic              full,
  input  logic              rd,
  output upc_pkg::upc_rec_t rdata,
  output logic              empty
);

  upc_pkg::upc_rec_t              mem [upc_pkg::FIFO_DEPTH];
  logic [upc_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [upc_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [upc_pkg::FIFO_CNT_W-1:0] count;

  assign full  = count == upc_pkg::FIFO_CNT_W'(upc_pkg::FIFO_DEPTH);
  assign empty = count == '0;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

  `UPC_ASSERT_NOW(a_fifo_bound, count <= upc_pkg::FIFO_CNT_W'(upc_pkg::FIFO_DEPTH), "fifo overfilled")

endmodule

@@ hdl/upc_back.sv @@
// back end: frame counters and the result register
// depends on upc_pkg and the assertion macro header
`include "udp_port_packet_classifier_core_defines.svh"

module upc_back #(
  parameter int NUM_QUEUES   = upc_pkg::NUM_QUEUES_DEF,
  parameter int COUNTER_BITS = upc_pkg::COUNTER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fifo_empty,
  input  upc_pkg::upc_rec_t             fifo_rec,
  output logic                          fifo_rd,
  input  logic                          pop,
  output logic                          out_valid,
  output logic                          redirect,
  output logic [upc_pkg::QUEUE_W-1:0]   target_queue,
  output logic [upc_pkg::OUT_CNT_W-1:0] udp_seen_total,
  output logic [upc_pkg::OUT_CNT_W-1:0] port_hit_total,
  output logic [upc_pkg::OUT_CNT_W-1:0] queue_redirect_total
);

  // only queues the two-bit queue field can name are stored
  localparam int QDEPTH = (NUM_QUEUES < 4) ? NUM_QUEUES : 4;
  localparam int QIDX_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  logic [COUNTER_BITS-1:0] udp_cnt;
  logic [COUNTER_BITS-1:0] hit_cnt;
  logic [COUNTER_BITS-1:0] queue_cnt [QDEPTH];

  logic                    take;
  logic [QIDX_W-1:0]       qidx;
  logic [COUNTER_BITS-1:0] udp_cnt_next;
  logic [COUNTER_BITS-1:0] hit_cnt_next;
  logic [COUNTER_BITS-1:0] qcnt_cur;
  logic [COUNTER_BITS-1:0] qcnt_next;

  assign take    = !fifo_empty && (!out_valid || pop);
  assign fifo_rd = take;
  assign qidx    = fifo_rec.queue[QIDX_W-1:0];

  assign udp_cnt_next = udp_cnt + COUNTER_BITS'(fifo_rec.udp_inc);
  assign hit_cnt_next = hit_cnt + COUNTER_BITS'(fifo_rec.hit_inc);
  assign qcnt_cur     = fifo_rec.qvalid ? queue_cnt[qidx] : '0;
  assign qcnt_next    = qcnt_cur + COUNTER_BITS'(fifo_rec.redirect);

  always_ff @(posedge clk) begin
    if (rst) begin
      udp_cnt <= '0;
      hit_cnt <= '0;
      for (int i = 0; i < QDEPTH; i++) queue_cnt[i] <= '0;
    end else if (take) begin
      udp_cnt <= udp_cnt_next;
      hit_cnt <= hit_cnt_next;
      if (fifo_rec.qvalid && fifo_rec.redirect) queue_cnt[qidx] <= qcnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      redirect             <= fifo_rec.redirect;
      target_queue         <= fifo_rec.queue;
      udp_seen_total       <= upc_pkg::OUT_CNT_W'(64'(udp_cnt_next));
      port_hit_total       <= upc_pkg::OUT_CNT_W'(64'(hit_cnt_next));
      queue_redirect_total <= upc_pkg::OUT_CNT_W'(64'(qcnt_next));
    end
  end

  `UPC_ASSERT_NOW(a_hit_is_udp, !take || !fifo_rec.hit_inc || fifo_rec.udp_inc, "hit without udp")
  `UPC_ASSERT_NEXT(a_udp_step, take && fifo_rec.udp_inc, udp_cnt == $past(udp_cnt) + COUNTER_BITS'(1), "udp count slip")

endmodule

@@ bench/udp_port_packet_classifier_core_tb.sv @@
// self-checking bench for udp_port_packet_classifier_core: frame bytes in, verdicts out
// uses upc_pkg for port widths and register codes; verdicts checked against a local predictor
module udp_port_packet_classifier_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // frame layout and protocol values, kept local so the bench does not lean on the rtl
  localparam logic [15:0] ETH_IPV4        = 16'h0800;
  localparam logic [7:0]  IPPROTO_UDP_NUM = 8'd17;
  localparam logic [7:0]  PROTO_DIVERT    = 8'd248;
  localparam int          MIN_IP_LEN      = 34;
  localparam int          MIN_UDP_LEN     = 42;
  localparam logic [5:0]  AT_ETYPE_HI     = 6'd12;
  localparam logic [5:0]  AT_ETYPE_LO     = 6'd13;
  localparam logic [5:0]  AT_PROTO        = 6'd23;
  localparam logic [5:0]  AT_DPORT_HI     = 6'd36;
  localparam logic [5:0]  AT_DPORT_LO     = 6'd37;
  localparam logic [5:0]  LAST_POS        = 6'd63;

  // register byte addresses
  localparam logic [upc_pkg::PADDR_W-1:0] ADDR_MASK   = {upc_pkg::REG_QUEUE_ENABLE, 2'b00};
  localparam logic [upc_pkg::PADDR_W-1:0] ADDR_PORT_A = {upc_pkg::REG_PORT_A, 2'b00};
  localparam logic [upc_pkg::PADDR_W-1:0] ADDR_PORT_B = {upc_pkg::REG_PORT_B, 2'b00};
  localparam logic [upc_pkg::PADDR_W-1:0] ADDR_PORT_C = {upc_pkg::REG_PORT_C, 2'b00};
  localparam logic [upc_pkg::PADDR_W-1:0] ADDR_PORT_D = {upc_pkg::REG_PORT_D, 2'b00};
  localparam logic [upc_pkg::PADDR_W-1:0] ADDR_VALID  = {upc_pkg::REG_PORT_VALID, 2'b00};
  localparam logic [upc_pkg::PADDR_W-1:0] ADDR_UNUSED = 5'd24;
  localparam logic [upc_pkg::PADDR_W-1:0] PORT_ADDR [4] =
    '{ADDR_PORT_A, ADDR_PORT_B, ADDR_PORT_C, ADDR_PORT_D};

  localparam int RANDOM_BYTES   = 900;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic        redirect;
    logic [1:0]  queue;
    logic [31:0] udp_seen;
    logic [31:0] port_hit;
    logic [31:0] queue_redirects;
  } verdict_t;

  typedef enum logic [1:0] {EXP_NONE, EXP_PASS, EXP_REDIRECT} exp_t;
  typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;
  typedef enum logic {ROW_FRAME, ROW_WRITE} row_kind_t;

  // one row of the directed table: a register write or one whole frame
  typedef struct packed {
    row_kind_t                   kind;
    logic [upc_pkg::PADDR_W-1:0] addr;
    logic [31:0]                 value;
    logic [7:0]                  len;
    logic [15:0]                 etype;
    logic [7:0]                  proto;
    logic [15:0]                 dport;
    logic [1:0]                  queue;
    fill_t                       fill;
    exp_t                        want;
  } row_t;

  localparam int NUM_ROWS = 28;
  localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // out of reset nothing is enabled, so even a well-formed udp frame passes
    '{ROW_FRAME, '0, '0, 8'd42, ETH_IPV4, IPPROTO_UDP_NUM, 16'd53, 2'd0, FILL_RANDOM, EXP_PASS},
    // every register, upper data bits set on all but ports c and d to show they are dropped
    '{ROW_WRITE, ADDR_MASK,   32'hFFFF_FFFF, '0, '0, '0, '0, '0, FILL_RANDOM, EXP_NONE},
    '{ROW_WRITE, ADDR_PORT_A, 32'hFFFF_0000, '0, '0, '0, '0, '0, FILL_RANDOM, EXP_NONE},
    '{ROW_WRITE, ADDR_PORT_B, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, FILL_RANDOM, EXP_NONE},
    '{ROW_WRITE, ADDR_PORT_C, 32'h0000_0035, '0, '0, '0, '0, '0, FILL_RANDOM, EXP_NONE},
    '{ROW_WRITE, ADDR_PORT_D, 32'h0000_1234, '0, '0, '0, '0, '0, FILL_RANDOM, EXP_NONE},
    '{ROW_WRITE, ADDR_VALID,  32'hFFFF_FFFF, '0, '0, '0, '0, '0, FILL_RANDOM, EXP_NONE},
    // unknown register index must not disturb anything
    '{ROW_WRITE, ADDR_UNUSED, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, FILL_RANDOM, EXP_NONE},
    '{ROW_FRAME, '0, '0, 8'd42, ETH_IPV4, IPPROTO_UDP_NUM, 16'd53, 2'd0, FILL_RANDOM,
      EXP_REDIRECT},
    '{ROW_FRAME, '0, '0, 8'd64, ETH_IPV4, IPPROTO_UDP_NUM, 16'hFFFF, 2'd1, FILL_RANDOM,
      EXP_REDIRECT},
    '{ROW_FRAME, '0, '0, 8'd42, ETH_IPV4, IPPROTO_UDP_NUM, 16'h0000, 2'd2, FILL_RANDOM,
      EXP_REDIRECT},
    // udp on an enabled queue with no port match: counted, passed
    '{ROW_FRAME, '0, '0, 8'd50, ETH_IPV4, IPPROTO_UDP_NUM, 16'h1235, 2'd3, FILL_RANDOM,
      EXP_PASS},
    // one byte short of a full udp header
    '{ROW_FRAME, '0, '0, 8'd41, ETH_IPV4, IPPROTO_UDP_NUM, 16'd53, 2'd0, FILL_RANDOM,
      EXP_PASS},
    '{ROW_FRAME, '0, '0, 8'd34, ETH_IPV4, PROTO_DIVERT, 16'd0, 2'd1, FILL_RANDOM,
      EXP_REDIRECT},
    '{ROW_FRAME, '0, '0, 8'd33, ETH_IPV4, PROTO_DIVERT, 16'd0, 2'd1, FILL_RANDOM, EXP_PASS},
    '{ROW_FRAME, '0, '0, 8'd42, 16'h86DD, IPPROTO_UDP_NUM, 16'd53, 2'd2, FILL_RANDOM,
      EXP_PASS},
    '{ROW_FRAME, '0, '0, 8'd60, ETH_IPV4, 8'd6, 16'd53, 2'd3, FILL_RANDOM, EXP_PASS},
    '{ROW_FRAME, '0, '0, 8'd1, '0, '0, '0, 2'd0, FILL_ONES, EXP_PASS},
    '{ROW_FRAME, '0, '0, 8'd14, ETH_IPV4, '0, '0, 2'd2, FILL_RANDOM, EXP_PASS},
    // long frame: position saturates, captured port still used
    '{ROW_FRAME, '0, '0, 8'd100, ETH_IPV4, IPPROTO_UDP_NUM, 16'h1234, 2'd3, FILL_RANDOM,
      EXP_REDIRECT},
    '{ROW_FRAME, '0, '0, 8'd64, '0, '0, '0, 2'd0, FILL_ONES, EXP_PASS},
    // queues 0 and 2 only, port b only
    '{ROW_WRITE, ADDR_MASK,  32'hFFFF_FFF5, '0, '0, '0, '0, '0, FILL_RANDOM, EXP_NONE},
    '{ROW_WRITE, ADDR_VALID, 32'h0000_0002, '0, '0, '0, '0, '0, FILL_RANDOM, EXP_NONE},
    '{ROW_FRAME, '0, '0, 8'd42, ETH_IPV4, IPPROTO_UDP_NUM, 16'd53, 2'd0, FILL_RANDOM, EXP_PASS},
    '{ROW_FRAME, '0, '0, 8'd42, ETH_IPV4, IPPROTO_UDP_NUM, 16'hFFFF, 2'd1, FILL_RANDOM,
      EXP_PASS},
    '{ROW_FRAME, '0, '0, 8'd42, ETH_IPV4, IPPROTO_UDP_NUM, 16'hFFFF, 2'd2, FILL_RANDOM,
      EXP_REDIRECT},
    '{ROW_FRAME, '0, '0, 8'd40, ETH_IPV4, PROTO_DIVERT, 16'd0, 2'd3, FILL_RANDOM, EXP_PASS},
    '{ROW_FRAME, '0, '0, 8'd42, ETH_IPV4, IPPROTO_UDP_NUM, 16'h0000, 2'd0, FILL_RANDOM,
      EXP_PASS}
  };

  logic                          clk;
  logic                          rst;
  logic                          push;
  logic                          full;
  logic [7:0]                    data_byte;
  logic [upc_pkg::QUEUE_W-1:0]   frame_queue;
  logic                          last_byte;
  logic                          empty;
  logic                          pop;
  logic                          redirect;
  logic [upc_pkg::QUEUE_W-1:0]   target_queue;
  logic [upc_pkg::OUT_CNT_W-1:0] udp_seen_total;
  logic [upc_pkg::OUT_CNT_W-1:0] port_hit_total;
  logic [upc_pkg::OUT_CNT_W-1:0] queue_redirect_total;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [upc_pkg::PADDR_W-1:0]   paddr;
  logic [upc_pkg::PDATA_W-1:0]   pwdata;
  logic [upc_pkg::PDATA_W-1:0]   prdata;
  logic                          pready;

  udp_port_packet_classifier_core uut (
    .clk                  (clk),
    .rst                  (rst),
    .push                 (push),
    .full                 (full),
    .data_byte            (data_byte),
    .frame_queue          (frame_queue),
    .last_byte            (last_byte),
    .empty                (empty),
    .pop                  (pop),
    .redirect             (redirect),
    .target_queue         (target_queue),
    .udp_seen_total       (udp_seen_total),
    .port_hit_total       (port_hit_total),
    .queue_redirect_total (queue_redirect_total),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  // predictor copy of the registers
  logic [3:0]  cfg_mask;
  logic [15:0] cfg_port [4];
  logic [3:0]  cfg_port_ok;

  // predictor copy of the frame parser and counters
  logic [5:0]  byte_pos;
  logic [15:0] cap_etype;
  logic [7:0]  cap_proto;
  logic [15:0] cap_dport;
  logic [31:0] udp_total;
  logic [31:0] hit_total;
  logic [31:0] redir_total [4];

  verdict_t    pending_verdicts [$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  int unsigned bytes_sent;
  int          burst_left;
  exp_t        typed_verdict;   // verdict read off the directed table, if any
  logic        hold_req;        // asks the receiver for one long hold-off

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // register write as seen by the block: index from the word address
  task automatic apply_write(input logic [upc_pkg::PADDR_W-1:0] addr, input logic [31:0] data);
    case (addr[4:2])
      upc_pkg::REG_QUEUE_ENABLE: cfg_mask    = data[3:0];
      upc_pkg::REG_PORT_A:       cfg_port[0] = data[15:0];
      upc_pkg::REG_PORT_B:       cfg_port[1] = data[15:0];
      upc_pkg::REG_PORT_C:       cfg_port[2] = data[15:0];
      upc_pkg::REG_PORT_D:       cfg_port[3] = data[15:0];
      upc_pkg::REG_PORT_VALID:   cfg_port_ok = data[3:0];
      default: ;
    endcase
  endtask

  // step the parser by one accepted byte; a last byte yields one verdict
  task automatic classify_byte(input logic [7:0] b, input logic [1:0] q, input logic lst);
    verdict_t    v;
    logic [5:0]  at;
    logic [6:0]  flen;
    logic        match;
    int          k;
    at = byte_pos;
    case (at)
      AT_ETYPE_HI: cap_etype[15:8] = b;
      AT_ETYPE_LO: cap_etype[7:0]  = b;
      AT_PROTO:    cap_proto       = b;
      AT_DPORT_HI: cap_dport[15:8] = b;
      AT_DPORT_LO: cap_dport[7:0]  = b;
      default: ;
    endcase
    if (at != LAST_POS) byte_pos = at + 6'd1;
    if (lst) begin
      flen = {1'b0, at} + 7'd1;
      v.redirect = 1'b0;
      if (cfg_mask[q] && cap_etype == ETH_IPV4 && flen >= MIN_IP_LEN) begin
        if (cap_proto == PROTO_DIVERT) begin
          v.redirect = 1'b1;
        end else if (cap_proto == IPPROTO_UDP_NUM && flen >= MIN_UDP_LEN) begin
          udp_total = udp_total + 1;
          match = 1'b0;
          for (k = 0; k < 4; k++)
            if (cfg_port_ok[k] && cfg_port[k] == cap_dport) match = 1'b1;
          if (match) begin
            hit_total = hit_total + 1;
            v.redirect = 1'b1;
          end
        end
      end
      // directed rows pin the verdict by hand
      if (typed_verdict != EXP_NONE) v.redirect = (typed_verdict == EXP_REDIRECT);
      if (v.redirect) redir_total[q] = redir_total[q] + 1;
      v.queue           = q;
      v.udp_seen        = udp_total;
      v.port_hit        = hit_total;
      v.queue_redirects = redir_total[q];
      pending_verdicts.push_back(v);
      byte_pos  = '0;
      cap_etype = '0;
      cap_proto = '0;
      cap_dport = '0;
    end
  endtask

  task automatic check_verdict();
    verdict_t e;
    if (pending_verdicts.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("unexpected verdict at %0t: redirect=%0d queue=%0d", $time, redirect,
                 target_queue);
    end else begin
      e = pending_verdicts.pop_front();
      if (redirect !== e.redirect || target_queue !== e.queue ||
          udp_seen_total !== e.udp_seen || port_hit_total !== e.port_hit ||
          queue_redirect_total !== e.queue_redirects) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("verdict mismatch at %0t: exp %0d q%0d udp %0d hit %0d qcnt %0d, ",
                   $time, e.redirect, e.queue, e.udp_seen, e.port_hit, e.queue_redirects,
                   "got %0d q%0d udp %0d hit %0d qcnt %0d",
                   redirect, target_queue, udp_seen_total, port_hit_total,
                   queue_redirect_total);
      end
    end
  endtask

  // everything is sampled at the rising edge; inputs only move on the falling edge
  always @(posedge clk) begin : monitor
    logic progress;
    if (rst) begin
      byte_pos  = '0;
      cap_etype = '0;
      cap_proto = '0;
      cap_dport = '0;
      udp_total = '0;
      hit_total = '0;
      for (int k = 0; k < 4; k++) begin
        redir_total[k] = '0;
        cfg_port[k]    = '0;
      end
      cfg_mask    = '0;
      cfg_port_ok = '0;
      idle_cycles = 0;
    end else begin
      progress = 1'b0;
      if (psel && penable && pwrite && pready) begin
        apply_write(paddr, pwdata);
        progress = 1'b1;
      end
      if (push && !full) begin
        classify_byte(data_byte, frame_queue, last_byte);
        progress = 1'b1;
      end
      if (pop && !empty) begin
        check_verdict();
        progress = 1'b1;
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      // nothing moving for this long means the block hung
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // receiver: windows of always-pop, half-rate, rare pops and full stall,
  // plus one long hold-off on request so the verdict queue fills and push backs up
  initial begin : receiver
    int window;
    int mode;
    pop = 1'b0;
    forever begin
      window = $urandom_range(1, 40);
      mode   = $urandom_range(0, 3);
      repeat (window) begin
        @(negedge clk);
        if (hold_req) begin
          pop = 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_req = 1'b0;
        end
        case (mode)
          0: pop = 1'b1;
          1: pop = ($urandom_range(0, 1) == 0);
          2: pop = ($urandom_range(0, 5) == 0);
          default: pop = 1'b0;
        endcase
      end
    end
  end

  // offer one byte, honoring the burst/gap pattern; entered and left at a falling edge
  task automatic push_byte(input logic [7:0] b, input logic [1:0] q, input logic lst);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        push = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    push        = 1'b1;
    data_byte   = b;
    frame_queue = q;
    last_byte   = lst;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  // one frame; header fields land at their offsets unless the frame is a flat fill
  task automatic send_frame(input int len, input logic [15:0] et, input logic [7:0] pr,
                            input logic [15:0] dp, input logic [1:0] q, input fill_t fill,
                            input exp_t want);
    logic [7:0] b;
    int i;
    typed_verdict = want;
    for (i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        default: begin
          b = 8'($urandom);
          if (i == AT_ETYPE_HI) b = et[15:8];
          if (i == AT_ETYPE_LO) b = et[7:0];
          if (i == AT_PROTO)    b = pr;
          if (i == AT_DPORT_HI) b = dp[15:8];
          if (i == AT_DPORT_LO) b = dp[7:0];
        end
      endcase
      // queue only matters on the last byte; wiggle it elsewhere
      push_byte(b, (i == len - 1) ? q : 2'($urandom), i == len - 1);
    end
    typed_verdict = EXP_NONE;
  endtask

  // nearly half well-formed udp with a fair share of matching ports, then divert, short,
  // noise and wrong-header frames
  task automatic random_frame();
    int          pick;
    int          len;
    logic [15:0] et;
    logic [15:0] dp;
    logic [7:0]  pr;
    pick = $urandom_range(0, 99);
    et   = ETH_IPV4;
    pr   = IPPROTO_UDP_NUM;
    len  = $urandom_range(MIN_UDP_LEN, 64);
    if ($urandom_range(0, 19) == 0) len = $urandom_range(65, 90);
    dp = ($urandom_range(0, 4) < 3) ? cfg_port[$urandom_range(0, 3)] : 16'($urandom);
    case ($urandom_range(0, 19))
      0: dp = 16'h0000;
      1: dp = 16'hFFFF;
      default: ;
    endcase
    if (pick >= 45 && pick < 60) begin
      pr  = PROTO_DIVERT;
      len = $urandom_range(MIN_IP_LEN - 4, 64);
    end else if (pick >= 60 && pick < 75) begin
      pr  = ($urandom_range(0, 1) == 0) ? IPPROTO_UDP_NUM : PROTO_DIVERT;
      len = $urandom_range(1, MIN_UDP_LEN - 1);
    end else if (pick >= 75 && pick < 85) begin
      et  = 16'($urandom);
      pr  = 8'($urandom);
      len = $urandom_range(1, 64);
    end else if (pick >= 85) begin
      if ($urandom_range(0, 1) == 0) et = 16'($urandom);
      else pr = 8'($urandom);
    end
    send_frame(len, et, pr, dp, 2'($urandom), FILL_RANDOM, EXP_NONE);
  endtask

  // apb write: setup, then access; psel is left high, callers drop it when done
  task automatic cfg_write(input logic [upc_pkg::PADDR_W-1:0] addr, input logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    penable = 1'b0;
  endtask

  // drain every outstanding verdict, then leave a margin for the pipeline
  task automatic wait_idle();
    push = 1'b0;
    psel = 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // new register setting per phase, all-off and all-on extremes among them
  task automatic random_config();
    int          style;
    int          k;
    logic [31:0] w;
    style = $urandom_range(0, 4);
    w = $urandom;
    w[3:0] = (style == 0) ? 4'h0 : (style == 1) ? 4'hF : 4'($urandom);
    cfg_write(ADDR_MASK, w);
    for (k = 0; k < 4; k++) begin
      w = $urandom;
      if (style == 0) w[15:0] = 16'h0000;
      else if (style == 1) w[15:0] = 16'hFFFF;
      else if ($urandom_range(0, 3) == 0) w[15:0] = ($urandom_range(0, 1) == 0) ? 16'h0 : 16'hFFFF;
      cfg_write(PORT_ADDR[k], w);
    end
    w = $urandom;
    if (style == 0) w[3:0] = 4'h0;
    else if (style == 1 || $urandom_range(0, 1) == 0) w[3:0] = 4'hF;
    cfg_write(ADDR_VALID, w);
    psel = 1'b0;
  endtask

  initial begin : stimulus
    row_t        row;
    int          r;
    int unsigned rnd_first;
    logic        hold_done;
    rst            = 1'b1;
    push           = 1'b0;
    data_byte      = '0;
    frame_queue    = '0;
    last_byte      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    hold_req       = 1'b0;
    typed_verdict  = EXP_NONE;
    burst_left     = 0;
    bytes_sent     = 0;
    mismatch_count = 0;
    hold_done      = 1'b0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // directed table
    for (r = 0; r < NUM_ROWS; r++) begin
      row = DIRECTED_ROWS[r];
      if (row.kind == ROW_WRITE) begin
        wait_idle();
        cfg_write(row.addr, row.value);
      end else begin
        send_frame(row.len, row.etype, row.proto, row.dport, row.queue, row.fill, row.want);
      end
    end

    // random phases, each with its own register setting
    rnd_first = bytes_sent;
    while (bytes_sent - rnd_first < RANDOM_BYTES) begin
      wait_idle();
      random_config();
      if (!hold_done && bytes_sent - rnd_first > RANDOM_BYTES / 3) begin
        // tiny frames while the receiver is held off: the verdict queue fills
        hold_done = 1'b1;
        hold_req  = 1'b1;
        repeat (16)
          send_frame($urandom_range(1, 3), ETH_IPV4, IPPROTO_UDP_NUM, 16'h0, 2'($urandom),
                     FILL_RANDOM, EXP_NONE);
      end
      repeat ($urandom_range(6, 14)) random_frame();
    end

    push = 1'b0;
    psel = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    // margin for any stray verdict after the last expected one
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_verdicts.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
